/* hw/rtl/smu_pkg.sv */
// shared types, register indexes and arithmetic helpers of the momentum update unit
`default_nettype none

package smu_pkg;

    localparam int SMU_PARAM_DEPTH = 4096;
    localparam int IDX_W           = 12;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LR_FRAC        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM_COEFF = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NESTEROV_MODE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE_MODE  = 8'd3;

    localparam logic [15:0] LR_RESET = 16'd655;

    typedef struct packed {
        logic [IDX_W-1:0]   elem_index;
        logic signed [31:0] grad_value;
        logic signed [31:0] data_value;
    } smu_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic signed [31:0] new_value;
        logic               saturated;
    } smu_out_t;

    typedef struct packed {
        logic [15:0] lr_frac;
        logic [15:0] momentum_coeff;
        logic        nesterov_mode;
        logic        maximize_mode;
    } smu_cfg_t;

    // item as it moves down the pipe, gradient already sign-corrected
    typedef struct packed {
        logic [IDX_W-1:0]   elem_index;
        logic signed [32:0] grad;
        logic signed [31:0] data;
    } smu_item_t;

    typedef struct packed {
        logic               valid;
        smu_item_t          item;
        logic signed [31:0] mom;
        logic               sat;
    } smu_mom_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } smu_clip_t;

    // floor(coef * x / 2^16)
    function automatic logic signed [33:0] smu_qmul(input logic [15:0] coef,
                                                    input logic signed [33:0] x);
        logic signed [50:0] p;
        p = $signed({35'b0, coef}) * 51'(x);
        return $signed(p[49:16]);
    endfunction

    function automatic smu_clip_t smu_clip(input logic signed [34:0] x);
        smu_clip_t r;
        r.sat = 1'b0;
        r.val = $signed(x[31:0]);
        if (x > 35'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'sh7fffffff;
        end else if (x < -35'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/smu_slot_map.sv */
// input stage: gradient sign, element index folded onto the momentum store depth
`default_nettype none

module smu_slot_map #(
    parameter int   PARAM_DEPTH = 4096,
    localparam int  AW          = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic             accept,
    input  wire logic             maximize,
    input  wire smu_pkg::smu_in_t in_item,
    output logic                  v0,
    output smu_pkg::smu_item_t    item0,
    output logic [AW-1:0]         slot0
);
    import smu_pkg::*;

    logic              v0_reg;
    smu_item_t         item0_reg;
    smu_item_t         item0_next;
    logic signed [32:0] grad_ext;

    assign grad_ext = {in_item.grad_value[31], in_item.grad_value};

    always_comb begin
        item0_next.elem_index = in_item.elem_index;
        item0_next.grad       = maximize ? -grad_ext : grad_ext;
        item0_next.data       = in_item.data_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item0_reg <= item0_next;
        end
    end

    generate
        if (PARAM_DEPTH >= (1 << IDX_W)) begin : g_direct
            assign slot0 = AW'(item0_reg.elem_index);
        end else begin : g_recip
            // quotient by reciprocal multiply, exact for 12-bit indexes
            localparam logic [24:0] RECIP = 25'(((1 << 24) + PARAM_DEPTH - 1) / PARAM_DEPTH);
            localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(PARAM_DEPTH);
            logic [36:0]      qprod;
            logic [IDX_W-1:0] q_reg;
            logic [IDX_W-1:0] q_next;
            logic [23:0]      qd;
            logic [IDX_W-1:0] rem;

            assign qprod  = {25'b0, in_item.elem_index} * {12'b0, RECIP};
            assign q_next = qprod[35:24];

            always_ff @(posedge aclk) begin
                if (adv) begin
                    q_reg <= q_next;
                end
            end

            assign qd    = {12'b0, q_reg} * {12'b0, DEPTH_C};
            assign rem   = item0_reg.elem_index - qd[IDX_W-1:0];
            assign slot0 = AW'(rem);
        end
    endgenerate

    assign v0    = v0_reg;
    assign item0 = item0_reg;

endmodule

`default_nettype wire

/* hw/rtl/smu_momentum.sv */
// momentum store with clearing pass, read-modify-write stage and forwarding
`default_nettype none

module smu_momentum #(
    parameter int   PARAM_DEPTH = 4096,
    localparam int  AW          = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire logic               v0,
    input  wire smu_pkg::smu_item_t item0,
    input  wire logic [AW-1:0]      slot0,
    input  wire logic [15:0]        coeff,
    output logic                    clr_busy,
    output smu_pkg::smu_mom_t       st2
);
    import smu_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(PARAM_DEPTH - 1);

    logic [31:0] mem [PARAM_DEPTH];

    logic               clr_busy_reg, clr_busy_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;

    logic               v1_reg;
    smu_item_t          item1_reg;
    logic [AW-1:0]      slot1_reg;
    logic signed [31:0] rd_reg;

    logic               v2_reg;
    smu_item_t          item2_reg;
    logic [AW-1:0]      slot2_reg;
    logic signed [31:0] mom2_reg;
    logic               sat2_reg;

    logic signed [31:0] mom_old;
    logic signed [34:0] msum;
    smu_clip_t          mom_clip;

    // clearing pass after reset
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // the item one stage ahead writes on the same edge as this one reads
    assign mom_old  = (v2_reg && (slot2_reg == slot1_reg)) ? mom2_reg : rd_reg;
    assign msum     = 35'(smu_qmul(coeff, 34'(mom_old))) + 35'(item1_reg.grad);
    assign mom_clip = smu_clip(msum);

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (adv && v1_reg) begin
            mem[slot1_reg] <= mom_clip.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg <= $signed(mem[slot0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item1_reg <= item0;
            slot1_reg <= slot0;
            item2_reg <= item1_reg;
            slot2_reg <= slot1_reg;
            mom2_reg  <= mom_clip.val;
            sat2_reg  <= mom_clip.sat;
        end
    end

    assign clr_busy  = clr_busy_reg;
    assign st2.valid = v2_reg;
    assign st2.item  = item2_reg;
    assign st2.mom   = mom2_reg;
    assign st2.sat   = sat2_reg;

endmodule

`default_nettype wire

/* hw/rtl/smu_value_path.sv */
// update term, learning-rate product and saturating value update
`default_nettype none

module smu_value_path (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire smu_pkg::smu_mom_t st2,
    input  wire smu_pkg::smu_cfg_t cfg,
    output logic                   res_valid,
    output smu_pkg::smu_out_t      res_item
);
    import smu_pkg::*;

    logic                   v3_reg;
    logic [IDX_W-1:0]       idx3_reg;
    logic signed [31:0]     data3_reg;
    logic                   sat3_reg;
    logic signed [33:0]     upd3_reg, upd3_next;

    logic                   v4_reg;
    logic [IDX_W-1:0]       idx4_reg;
    logic signed [31:0]     data4_reg;
    logic                   sat4_reg;
    logic signed [33:0]     lrp4_reg, lrp4_next;

    logic signed [34:0]     res_sum;
    smu_clip_t              res_clip;

    // nesterov lookahead reuses the momentum coefficient
    assign upd3_next = cfg.nesterov_mode ?
                       smu_qmul(cfg.momentum_coeff, 34'(st2.mom)) + 34'(st2.item.grad) :
                       34'(st2.mom);
    assign lrp4_next = smu_qmul(cfg.lr_frac, upd3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= st2.valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx3_reg  <= st2.item.elem_index;
            data3_reg <= st2.item.data;
            sat3_reg  <= st2.sat;
            upd3_reg  <= upd3_next;
            idx4_reg  <= idx3_reg;
            data4_reg <= data3_reg;
            sat4_reg  <= sat3_reg;
            lrp4_reg  <= lrp4_next;
        end
    end

    assign res_sum  = 35'(data4_reg) - 35'(lrp4_reg);
    assign res_clip = smu_clip(res_sum);

    assign res_valid          = v4_reg;
    assign res_item.out_index = idx4_reg;
    assign res_item.new_value = res_clip.val;
    assign res_item.saturated = sat4_reg | res_clip.sat;

endmodule

`default_nettype wire

/* hw/rtl/smu_out_skid.sv */
// output register with one skid entry so the pipe keeps moving while a result waits
`default_nettype none

module smu_out_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire smu_pkg::smu_out_t in_item,
    output logic                   adv,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output smu_pkg::smu_out_t      m_item
);
    import smu_pkg::*;

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    smu_out_t main_reg, main_next;
    smu_out_t skid_reg, skid_next;
    logic     pop;
    logic     push;

    assign adv  = !skid_valid_reg;
    assign pop  = main_valid_reg && m_ready;
    assign push = in_valid && adv;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = in_item;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = in_item;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid = main_valid_reg;
    assign m_item  = main_reg;

endmodule

`default_nettype wire

/* hw/rtl/sgd_momentum_update_unit.sv */
// SGD with momentum (optional Nesterov) update unit, top level
//
// One parameter element per cycle, sustained while the output skid is not full
// and no clearing pass runs, including back-to-back items on the same index:
// the momentum read-modify-write stage forwards the value the item one stage
// ahead is writing. An accepted s_item passes the slot stage, momentum read,
// momentum update, update term and learning-rate product registers, then the
// output register, before m_valid rises. After reset the momentum store is
// cleared one entry per cycle with s_ready low; configuration writes are taken
// during that pass. Write configuration only while no item is in flight.
`default_nettype none

module sgd_momentum_update_unit #(
    parameter int PARAM_DEPTH = smu_pkg::SMU_PARAM_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire smu_pkg::smu_in_t                s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output smu_pkg::smu_out_t                    m_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [smu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import smu_pkg::*;

    localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;

    smu_cfg_t      cfg_reg, cfg_next;
    logic          adv;
    logic          clr_busy;
    logic          accept;
    logic          v0;
    smu_item_t     item0;
    logic [AW-1:0] slot0;
    smu_mom_t      st2;
    logic          res_valid;
    smu_out_t      res_item;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LR_FRAC:        cfg_next.lr_frac        = cfg_data[15:0];
                CFG_MOMENTUM_COEFF: cfg_next.momentum_coeff = cfg_data[15:0];
                CFG_NESTEROV_MODE:  cfg_next.nesterov_mode  = cfg_data[0];
                CFG_MAXIMIZE_MODE:  cfg_next.maximize_mode  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lr_frac        <= LR_RESET;
            cfg_reg.momentum_coeff <= '0;
            cfg_reg.nesterov_mode  <= 1'b0;
            cfg_reg.maximize_mode  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = adv && !clr_busy;
    assign accept  = s_valid && s_ready;

    smu_slot_map #(
        .PARAM_DEPTH(PARAM_DEPTH)
    ) u_slot_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .accept   (accept),
        .maximize (cfg_reg.maximize_mode),
        .in_item  (s_item),
        .v0       (v0),
        .item0    (item0),
        .slot0    (slot0)
    );

    smu_momentum #(
        .PARAM_DEPTH(PARAM_DEPTH)
    ) u_momentum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .v0       (v0),
        .item0    (item0),
        .slot0    (slot0),
        .coeff    (cfg_reg.momentum_coeff),
        .clr_busy (clr_busy),
        .st2      (st2)
    );

    smu_value_path u_value_path (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .st2       (st2),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    smu_out_skid u_out_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_item  (res_item),
        .adv      (adv),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
// testbench for the sgd momentum update unit: driver, monitor and a bit-exact predictor
`timescale 1ns / 1ps

module tb;
    import smu_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 10;
    localparam int HOLDOFF_LEN = 400;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 130;

    logic aclk;
    logic aresetn = 1'b0;

    logic     s_valid = 1'b0;
    logic     s_ready;
    smu_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    smu_out_t m_item;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    sgd_momentum_update_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // predictor state: register copy and per-element momentum
    smu_cfg_t           cur_cfg;
    logic signed [31:0] mom_table [0:SMU_PARAM_DEPTH-1];

    smu_in_t  elems_to_send [$];
    smu_out_t updates_due   [$];

    int  mismatches    = 0;
    int  updates_seen  = 0;
    int  clipped_seen  = 0;
    int  settings_used = 0;
    int  idle_cycles   = 0;
    bit  elem_taken    = 1'b0;
    int  burst_left    = 0;
    int  gap_left      = 0;
    bit  holdoff_req   = 1'b0;
    int  holdoff_left  = 0;
    int  rx_window     = 0;
    int  rx_mode       = 0;

    // floor(coef * x / 2^16)
    function automatic longint scale_floor(input logic [15:0] coef, input longint x);
        return (longint'(coef) * x) >>> 16;
    endfunction

    function automatic longint clip_q16(input longint x, inout logic hit);
        if (x > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic smu_out_t apply_momentum_step(input smu_in_t it);
        longint   g;
        longint   mom;
        longint   upd;
        longint   res;
        logic     hit;
        smu_out_t o;
        hit = 1'b0;
        g = longint'($signed(it.grad_value));
        if (cur_cfg.maximize_mode)
            g = -g;
        mom = scale_floor(cur_cfg.momentum_coeff, longint'(mom_table[it.elem_index])) + g;
        mom = clip_q16(mom, hit);
        mom_table[it.elem_index] = 32'(mom);
        upd = mom;
        if (cur_cfg.nesterov_mode)
            upd = scale_floor(cur_cfg.momentum_coeff, mom) + g;
        res = longint'($signed(it.data_value)) - scale_floor(cur_cfg.lr_frac, upd);
        res = clip_q16(res, hit);
        o.out_index = it.elem_index;
        o.new_value = 32'(res);
        o.saturated = hit;
        return o;
    endfunction

    function automatic logic signed [31:0] draw_q16();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3, 4: return $urandom();
            5, 6: return $signed($urandom()) >>> $urandom_range(4, 20);
            default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
        endcase
    endfunction

    function automatic smu_in_t draw_elem();
        smu_in_t it;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: it.elem_index = IDX_W'($urandom_range(0, 7));
            4: it.elem_index = $urandom_range(0, 1) ? '1 : '0;
            default: it.elem_index = IDX_W'($urandom());
        endcase
        it.grad_value = draw_q16();
        it.data_value = draw_q16();
        return it;
    endfunction

    function automatic void queue_elem(input logic [IDX_W-1:0] idx,
                                       input logic [31:0] grad, input logic [31:0] data);
        smu_in_t it;
        it.elem_index = idx;
        it.grad_value = grad;
        it.data_value = data;
        elems_to_send = {elems_to_send, it};
    endfunction

    // sender: bursts and gaps, item held until taken
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            updates_due = {updates_due, apply_momentum_step(s_item)};
            void'(elems_to_send.pop_front());
            elem_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (s_valid && !elem_taken) begin
            // still waiting for the block to take it
        end else if (gap_left != 0 || elems_to_send.size() == 0) begin
            if (gap_left != 0)
                gap_left--;
            s_valid <= 1'b0;
        end else begin
            s_valid <= 1'b1;
            s_item  <= elems_to_send[0];
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 48);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
                burst_left--;
            end
        end
        elem_taken = 1'b0;
    end

    // receiver: windows of full rate, half rate and sparse ready, plus long hold-off
    always @(negedge aclk) begin
        if (holdoff_req) begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_req  = 1'b0;
        end
        if (rx_window == 0) begin
            rx_window = $urandom_range(16, 160);
            rx_mode   = $urandom_range(0, 2);
        end else begin
            rx_window--;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        smu_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (updates_due.size() == 0) begin
                $display("%0t: unexpected result, actual index %0d value %0d sat %0b",
                         $time, m_item.out_index, $signed(m_item.new_value), m_item.saturated);
                mismatches++;
            end else begin
                want = updates_due.pop_front();
                check_field("out_index", want.out_index, m_item.out_index);
                check_field("new_value", $signed(want.new_value), $signed(m_item.new_value));
                check_field("saturated", want.saturated, m_item.saturated);
                updates_seen++;
                if (want.saturated)
                    clipped_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_LR_FRAC:        cur_cfg.lr_frac        = value[15:0];
            CFG_MOMENTUM_COEFF: cur_cfg.momentum_coeff = value[15:0];
            CFG_NESTEROV_MODE:  cur_cfg.nesterov_mode  = value[0];
            CFG_MAXIMIZE_MODE:  cur_cfg.maximize_mode  = value[0];
            default: ;
        endcase
    endtask

    // upper data bits are junk on purpose, plus one write to an unmapped index
    task automatic program_regs(input smu_cfg_t c);
        write_reg(CFG_MOMENTUM_COEFF, {16'($urandom()), c.momentum_coeff});
        write_reg(CFG_IDX_W'($urandom_range(CFG_MAXIMIZE_MODE + 1, (1 << CFG_IDX_W) - 1)),
                  $urandom());
        write_reg(CFG_LR_FRAC, {16'($urandom()), c.lr_frac});
        write_reg(CFG_NESTEROV_MODE, {31'($urandom()), c.nesterov_mode});
        write_reg(CFG_MAXIMIZE_MODE, {31'($urandom()), c.maximize_mode});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        while (elems_to_send.size() != 0 || updates_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        smu_cfg_t rand_cfg [RAND_PHASES];
        for (int i = 0; i < SMU_PARAM_DEPTH; i++)
            mom_table[i] = '0;
        cur_cfg = '{LR_RESET, 16'd0, 1'b0, 1'b0};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, index extremes
        queue_elem('1, 32'h7fffffff, 32'h80000000);
        queue_elem('0, 32'h80000000, 32'h7fffffff);
        queue_elem('1, 32'h00010000, 32'h00000000);
        drain();

        // everything at full scale, ascending, lookahead term
        program_regs('{16'hffff, 16'hffff, 1'b1, 1'b1});
        queue_elem(IDX_W'(5), 32'h7fffffff, 32'h00000000);
        // negated most negative gradient stays exact, momentum lands in range
        queue_elem(IDX_W'(5), 32'h80000000, 32'h00000000);
        // momentum runs past the positive limit
        queue_elem(IDX_W'(6), 32'h80000000, 32'h7fffffff);
        queue_elem(IDX_W'(6), 32'h80000000, 32'h80000000);
        // value driven below the negative limit, then above the positive one
        queue_elem(IDX_W'(7), 32'hffff0000, 32'h80000000);
        queue_elem(IDX_W'(8), 32'h00010000, 32'h7fffffff);
        queue_elem('1, 32'h7fffffff, 32'h80000000);
        queue_elem('1, 32'h7fffffff, 32'h7fffffff);
        queue_elem(IDX_W'(0), 32'h00000000, 32'h00000000);
        queue_elem(IDX_W'(0), 32'hffffffff, 32'h00000001);
        drain();

        // zero rate and coefficient: value passes through
        program_regs('{16'h0000, 16'h0000, 1'b0, 1'b0});
        queue_elem('1, 32'h80000000, 32'h80000000);
        queue_elem(IDX_W'(0), 32'h7fffffff, 32'h7fffffff);
        queue_elem(IDX_W'(1), 32'h80000000, 32'h7fffffff);
        queue_elem(IDX_W'(2), 32'h7fffffff, 32'h80000000);
        drain();

        program_regs('{16'hffff, 16'hffff, 1'b0, 1'b0});
        queue_elem(IDX_W'(3), 32'h7fffffff, 32'h80000000);
        queue_elem(IDX_W'(3), 32'h7fffffff, 32'h00000000);
        queue_elem(IDX_W'(3), 32'h80000000, 32'h7fffffff);
        drain();

        rand_cfg[0] = '{16'($urandom()), 16'($urandom()), 1'b0, 1'b0};
        rand_cfg[1] = '{16'hffff, 16'hffff, 1'b0, 1'b1};
        rand_cfg[2] = '{16'($urandom()), 16'($urandom_range(49152, 65535)), 1'b1, 1'b0};
        rand_cfg[3] = '{16'd1, 16'd1, 1'b1, 1'b1};
        rand_cfg[4] = '{16'($urandom()), 16'($urandom()), 1'($urandom()), 1'($urandom())};
        rand_cfg[5] = '{16'($urandom()), 16'($urandom()), 1'($urandom()), 1'($urandom())};

        for (int p = 0; p < RAND_PHASES; p++) begin
            program_regs(rand_cfg[p]);
            // receiver sits out a long stretch while items keep coming
            if (p == 1)
                holdoff_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender stops halfway until the pipe is empty
                if (p == 3 && n == PHASE_ITEMS / 2)
                    drain();
                elems_to_send = {elems_to_send, draw_elem()};
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("checked %0d element updates under %0d register settings",
                 updates_seen, settings_used);
        $display("%0d of them clipped the momentum or the value", clipped_seen);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* sgd_momentum_update_unit.f */
hw/rtl/smu_pkg.sv
hw/rtl/smu_slot_map.sv
hw/rtl/smu_momentum.sv
hw/rtl/smu_value_path.sv
hw/rtl/smu_out_skid.sv
hw/rtl/sgd_momentum_update_unit.sv
bench/tb.sv
